// ----- design/mhb_pkg.sv -----
// shared types and constants for the max-heap build block
// no dependencies; imported by mhb_heap_ram, max_heap_build and the testbench
`default_nettype none

package mhb_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

// ----- design/max_heap_build.sv -----
// Builds a binary max-heap from a stream of signed 32-bit values and streams the
// heap back out in index order. Loading accepts one request per cycle; a request
// flagged last_item closes the set. Heapify is bottom-up sift-down through a heap
// memory with one write and one read port: a start step per parent, then for each
// level examined: read left child, read right child, compare and write back,
// plus a final write-back step when the sift reaches a leaf. Results leave one
// at a time; the next is fetched only once the output has taken the current one.
// Requests beyond CAPACITY are dropped and flagged on every result of that set.
// No input is taken from the close of a set until its last result has been
// accepted.
// depends on mhb_pkg and mhb_heap_ram
`default_nettype none

module max_heap_build
  import mhb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire data_t in_value,
  input  wire logic  in_last_item,
  output logic       out_valid,
  input  wire logic  out_stall,
  output data_t      out_heap_value,
  output logic       out_final_out,
  output logic       out_overflow
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = IDX_W + 2;

  localparam logic [3:0] ST_LOAD  = 4'd0;
  localparam logic [3:0] ST_NODE  = 4'd1;
  localparam logic [3:0] ST_CHL   = 4'd2;
  localparam logic [3:0] ST_CHR   = 4'd3;
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_PUT   = 4'd5;
  localparam logic [3:0] ST_ERD   = 4'd6;
  localparam logic [3:0] ST_ELOAD = 4'd7;
  localparam logic [3:0] ST_EHOLD = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] par_r, par_nxt;
  logic [IDX_W-1:0] node_r, node_nxt;
  logic [IDX_W-1:0] e_r, e_nxt;
  logic             new_r, new_nxt;
  logic             hr_r, hr_nxt;
  data_t            v_r, v_nxt;
  data_t            lval_r, lval_nxt;
  logic             out_valid_r, out_valid_nxt;
  data_t            out_value_r, out_value_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  data_t            mem_wd;
  logic [IDX_W-1:0] mem_ra;
  data_t            mem_rd;

  logic             in_acc;
  logic [CW-1:0]    left_w, right_w, cnt_w, pleft_w;
  logic [CNT_W-1:0] half_w;
  logic             pick_right;
  data_t            pval;
  logic [IDX_W-1:0] pidx;

  mhb_heap_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;

  assign cnt_w      = CW'(cnt_r);
  assign left_w     = {1'b0, node_r, 1'b1};
  assign right_w    = left_w + CW'(1);
  assign pick_right = hr_r && (mem_rd > lval_r);
  assign pval       = pick_right ? mem_rd : lval_r;
  assign pidx       = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
  assign pleft_w    = {1'b0, pidx, 1'b1};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    par_nxt       = par_r;
    node_nxt      = node_r;
    e_nxt         = e_r;
    new_nxt       = new_r;
    hr_nxt        = hr_r;
    v_nxt         = v_r;
    lval_nxt      = lval_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    out_ovf_nxt   = out_ovf_r;
    mem_we        = 1'b0;
    mem_wa        = node_r;
    mem_wd        = v_r;
    mem_ra        = node_r;
    half_w        = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(CAPACITY)) begin
            mem_we  = 1'b1;
            mem_wa  = cnt_r[IDX_W-1:0];
            mem_wd  = in_value;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            half_w = cnt_nxt >> 1;
            if (half_w == '0) begin
              e_nxt     = '0;
              state_nxt = ST_ERD;
            end else begin
              par_nxt   = IDX_W'(half_w - CNT_W'(1));
              node_nxt  = IDX_W'(half_w - CNT_W'(1));
              new_nxt   = 1'b1;
              state_nxt = ST_NODE;
            end
          end
        end
      end
      ST_NODE: begin
        mem_ra    = node_r;
        state_nxt = ST_CHL;
      end
      ST_CHL: begin
        // entering from a fresh parent, the read data is the sifted value
        if (new_r) begin
          v_nxt = mem_rd;
        end
        new_nxt   = 1'b0;
        mem_ra    = left_w[IDX_W-1:0];
        state_nxt = ST_CHR;
      end
      ST_CHR: begin
        lval_nxt  = mem_rd;
        hr_nxt    = right_w < cnt_w;
        mem_ra    = right_w[IDX_W-1:0];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        mem_we = 1'b1;
        mem_wa = node_r;
        if (pval > v_r) begin
          // larger child moves up, keep carrying the sifted value
          mem_wd   = pval;
          node_nxt = pidx;
          if (pleft_w < cnt_w) begin
            state_nxt = ST_CHL;
          end else begin
            state_nxt = ST_PUT;
          end
        end else begin
          mem_wd = v_r;
          if (par_r == '0) begin
            e_nxt     = '0;
            state_nxt = ST_ERD;
          end else begin
            par_nxt   = par_r - IDX_W'(1);
            node_nxt  = par_r - IDX_W'(1);
            new_nxt   = 1'b1;
            state_nxt = ST_NODE;
          end
        end
      end
      ST_PUT: begin
        mem_we = 1'b1;
        mem_wa = node_r;
        mem_wd = v_r;
        if (par_r == '0) begin
          e_nxt     = '0;
          state_nxt = ST_ERD;
        end else begin
          par_nxt   = par_r - IDX_W'(1);
          node_nxt  = par_r - IDX_W'(1);
          new_nxt   = 1'b1;
          state_nxt = ST_NODE;
        end
      end
      ST_ERD: begin
        mem_ra    = e_r;
        state_nxt = ST_ELOAD;
      end
      ST_ELOAD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = mem_rd;
        out_final_nxt = (CNT_W'(e_r) + CNT_W'(1)) == cnt_r;
        out_ovf_nxt   = ovf_r;
        state_nxt     = ST_EHOLD;
      end
      ST_EHOLD: begin
        mem_ra = e_r + IDX_W'(1);
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_final_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            e_nxt     = e_r + IDX_W'(1);
            state_nxt = ST_ELOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    par_r       <= par_nxt;
    node_r      <= node_nxt;
    e_r         <= e_nxt;
    new_r       <= new_nxt;
    hr_r        <= hr_nxt;
    v_r         <= v_nxt;
    lval_r      <= lval_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_heap_value = out_value_r;
  assign out_final_out  = out_final_r;
  assign out_overflow   = out_ovf_r;

endmodule

`default_nettype wire

// ----- design/mhb_heap_ram.sv -----
// heap store: single write port, single read port, read data registered
// depends on mhb_pkg for the element type
`default_nettype none

module mhb_heap_ram
  import mhb_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire data_t         wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output data_t              rd_data
);

  data_t mem [DEPTH];
  data_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- test/tb_max_heap_build.sv -----
// testbench for max_heap_build: sends data sets of signed values, predicts the heap order
// and checks every emitted element, with random idling on both handshakes
// depends on mhb_pkg and the max_heap_build rtl
`timescale 1ns / 1ps

module tb_max_heap_build;
  import mhb_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int RAND_ITEMS  = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int NUM_DIR     = 20;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    data_t value;
    logic  final_flag;
    logic  ovf;
  } heap_res_t;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  typed;
    data_t exp_value;
  } stim_row_t;

  logic  clk          = 1'b0;
  logic  rst_n        = 1'b0;
  logic  in_valid     = 1'b0;
  data_t in_value     = '0;
  logic  in_last_item = 1'b0;
  logic  out_stall    = 1'b0;
  logic  in_stall;
  logic  out_valid;
  data_t out_heap_value;
  logic  out_final_out;
  logic  out_overflow;

  // predictor state
  data_t     model_mem [CAPACITY];
  int        model_cnt = 0;
  bit        model_ovf = 1'b0;
  heap_res_t pending_heap[$];

  int err_count  = 0;
  int idle_count = 0;
  int rx_left    = 0;
  bit rx_calm    = 1'b0;
  bit tx_calm    = 1'b0;

  // typed rows are single-element sets: the element comes straight back
  stim_row_t dir_rows [NUM_DIR] = '{
    '{32'sh7fffffff, 1'b1, 1'b1, 32'sh7fffffff},
    '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000},
    '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000},
    '{32'shffffffff, 1'b1, 1'b1, 32'shffffffff},
    // equal parent and child, no swap
    '{32'sd5, 1'b0, 1'b0, '0},
    '{32'sd5, 1'b1, 1'b0, '0},
    // equal children, left one wins
    '{32'sd1, 1'b0, 1'b0, '0},
    '{32'sd7, 1'b0, 1'b0, '0},
    '{32'sd7, 1'b1, 1'b0, '0},
    // ascending run, every parent sifts to a leaf
    '{32'sd1, 1'b0, 1'b0, '0},
    '{32'sd2, 1'b0, 1'b0, '0},
    '{32'sd3, 1'b0, 1'b0, '0},
    '{32'sd4, 1'b0, 1'b0, '0},
    '{32'sd5, 1'b0, 1'b0, '0},
    '{32'sd6, 1'b0, 1'b0, '0},
    '{32'sd7, 1'b1, 1'b0, '0},
    '{32'sh80000000, 1'b0, 1'b0, '0},
    '{32'sh7fffffff, 1'b0, 1'b0, '0},
    '{32'shffffffff, 1'b0, 1'b0, '0},
    '{32'sh00000000, 1'b1, 1'b0, '0}
  };

  max_heap_build #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last_item  (in_last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_heap_value(out_heap_value),
    .out_final_out (out_final_out),
    .out_overflow  (out_overflow)
  );

  always #10 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  function automatic data_t rand_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return data_t'($urandom);
    end else if (sel < 8) begin
      // narrow range, lots of equal keys
      return data_t'($urandom_range(0, 7)) - 32'sd4;
    end
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh00000000;
      default: return 32'shffffffff;
    endcase
  endfunction

  function automatic void sift_model(int node, int count);
    int    pick;
    data_t tmp;
    bit    done;
    done = 1'b0;
    while (!done) begin
      pick = 2 * node + 1;
      if (pick >= count) begin
        done = 1'b1;
      end else begin
        if (pick + 1 < count && model_mem[pick + 1] > model_mem[pick]) begin
          pick = pick + 1;
        end
        if (model_mem[pick] > model_mem[node]) begin
          tmp             = model_mem[node];
          model_mem[node] = model_mem[pick];
          model_mem[pick] = tmp;
          node            = pick;
        end else begin
          done = 1'b1;
        end
      end
    end
  endfunction

  function automatic void heap_accept(data_t v, logic last);
    heap_res_t r;
    if (model_cnt < CAPACITY) begin
      model_mem[model_cnt] = v;
      model_cnt++;
    end else begin
      model_ovf = 1'b1;
    end
    if (last) begin
      for (int k = model_cnt / 2; k > 0; k--) begin
        sift_model(k - 1, model_cnt);
      end
      for (int k = 0; k < model_cnt; k++) begin
        r.value      = model_mem[k];
        r.final_flag = (k == model_cnt - 1);
        r.ovf        = model_ovf;
        pending_heap.push_back(r);
      end
      model_cnt = 0;
      model_ovf = 1'b0;
    end
  endfunction

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_request(input data_t v, input logic last);
    int gap;
    gap = (tx_calm || $urandom_range(0, 3) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_value     <= v;
    in_last_item <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    heap_accept(v, last);
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heap.size() != 0) @(posedge clk);
  endtask

  // receiver: runs of ready and runs of stall
  always @(posedge clk) begin
    if (rx_left == 0) begin
      if (rx_calm || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(1, 12);
      end else begin
        out_stall <= 1'b1;
        rx_left = idle_len();
      end
    end else begin
      rx_left = rx_left - 1;
    end
  end

  always @(posedge clk) begin
    heap_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_heap.size() == 0) begin
        $display("%0t: unexpected result heap_value %0d", $time, out_heap_value);
        err_count++;
      end else begin
        exp_r = pending_heap.pop_front();
        if (out_heap_value !== exp_r.value) begin
          $display("%0t: heap_value expected %0d got %0d", $time, exp_r.value,
                   out_heap_value);
          err_count++;
        end
        if (out_final_out !== exp_r.final_flag) begin
          $display("%0t: final_out expected %0b got %0b", $time, exp_r.final_flag,
                   out_final_out);
          err_count++;
        end
        if (out_overflow !== exp_r.ovf) begin
          $display("%0t: overflow expected %0b got %0b", $time, exp_r.ovf, out_overflow);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request taken on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
    end
    if (idle_count >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    heap_res_t typed_r;
    int        items_sent;
    int        set_no;
    int        set_len;

    items_sent = 0;
    set_no     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].value, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        typed_r.value      = dir_rows[i].exp_value;
        typed_r.final_flag = 1'b1;
        typed_r.ovf        = 1'b0;
        pending_heap[pending_heap.size() - 1] = typed_r;
      end
    end
    drain_pause();

    while (items_sent < RAND_ITEMS) begin
      case (set_no)
        3:       set_len = CAPACITY;
        7:       set_len = CAPACITY + 1;  // closing element is the dropped one
        12:      set_len = CAPACITY + 6;
        default: set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, CAPACITY)
                                                        : $urandom_range(1, 16);
      endcase
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if (set_no % 5 == 4) begin
        drain_pause();
      end
      for (int k = 0; k < set_len; k++) begin
        send_request(rand_value(), k == set_len - 1);
      end
      items_sent += set_len;
      set_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_heap.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mhb_pkg.sv
design/mhb_heap_ram.sv
design/max_heap_build.sv
test/tb_max_heap_build.sv
